// ----- hw/rtl/mexp_pkg.sv -----
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int MOD_WIDTH_DEF = 32;
  localparam int EXP_WIDTH_DEF = 63;
  localparam int BASE_WIDTH    = 64;
  localparam int OUT_WIDTH     = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

endpackage

// ----- hw/rtl/mexp_key.sv -----
`timescale 1ns / 1ps

module mexp_key #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [MOD_WIDTH-1:0] modulus,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] mod_norm,
  output logic [MOD_WIDTH+1:0] mu
);

  localparam int W    = MOD_WIDTH;
  localparam int CW   = $clog2(2 * W + 1);
  localparam logic [CW-1:0] LAST = CW'(2 * W);

  typedef enum logic [1:0] {K_IDLE, K_NORM, K_DIV} kstate_t;

  kstate_t       state_r;
  logic          done_r;
  logic [W-1:0]  mn_r;
  logic [W+1:0]  mu_r;
  logic [W-1:0]  rem_r;
  logic [CW-1:0] cnt_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          qbit;

  // dividend is 2^(2W): a single one in its top bit
  always_comb begin
    trial = {rem_r, (cnt_r == '0)};
    diff  = trial - {1'b0, mn_r};
    qbit  = (trial >= {1'b0, mn_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= K_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        K_IDLE: begin
          if (go) begin
            mn_r    <= modulus;
            state_r <= K_NORM;
          end
        end
        K_NORM: begin
          if (mn_r[W-1]) begin
            rem_r   <= '0;
            cnt_r   <= '0;
            mu_r    <= '0;
            state_r <= K_DIV;
          end else begin
            mn_r <= mn_r << 1;
          end
        end
        K_DIV: begin
          rem_r <= qbit ? diff[W-1:0] : trial[W-1:0];
          mu_r  <= {mu_r[W:0], qbit};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == LAST) begin
            done_r  <= 1'b1;
            state_r <= K_IDLE;
          end
        end
        default: state_r <= K_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign mod_norm = mn_r;
  assign mu       = mu_r;

endmodule

// ----- hw/rtl/modular_exponentiation.sv -----
// A zero exponent or zero modulus is answered straight from idle; otherwise the word runs
//   base reduction digit by digit, then square-and-multiply over the exponent bits, then a fold
//   to the true modulus, all paced by one shared multiplier.
// After reset or a modulus write the next such word first waits for key setup.
// Throughput: one word at a time; busy is high until the result strobe.
// Reset (rst_n, synchronous): modulus 1, exponent 0, block idle; the receiver cannot stall.
`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mexp_pkg::BASE_WIDTH-1:0]   in_base_value,
  output logic                              out_valid,
  output logic [mexp_pkg::OUT_WIDTH-1:0]    out_power_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mexp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mexp_pkg::*;

  localparam int W    = MOD_WIDTH;
  localparam int E    = EXP_WIDTH;
  localparam int NDIG = (BASE_WIDTH + W - 1) / W;
  localparam int BW   = NDIG * W;
  localparam int DGW  = $clog2(NDIG + 1);
  localparam int MW   = W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_KEY, S_DIG, S_MUL, S_RQ, S_RM, S_SUB, S_FIX, S_FIN
  } state_t;

  typedef enum logic [1:0] {PH_BASE, PH_MULT, PH_SQR} phase_t;

  state_t               state_r;
  phase_t               phase_r;
  logic [W-1:0]         modulus_r;
  logic [E-1:0]         exponent_r;
  logic                 dirty_r;
  logic                 key_go_r;
  logic                 out_valid_r;
  logic [OUT_WIDTH-1:0] out_r;

  logic [BW-1:0]        base_r;
  logic [DGW-1:0]       dig_r;
  logic [E-1:0]         e_r;
  logic [W-1:0]         acc_r;
  logic [W-1:0]         pw_r;
  logic [2*W-1:0]       x_r;
  logic [W:0]           q3_r;
  logic [W+1:0]         qm_r;
  logic [W+1:0]         r_r;
  logic [W-1:0]         fr_r;
  logic [W-1:0]         d_r;

  logic                 key_done;
  logic [W-1:0]         mn;
  logic [W+1:0]         mu;

  logic [MW-1:0]        mul_a;
  logic [MW-1:0]        mul_b;
  logic [2*MW-1:0]      mul_p;
  logic [W+1:0]         m1;
  logic [W+1:0]         m2;
  logic [W+1:0]         red_full;
  logic [W-1:0]         red;
  logic [E-1:0]         e_sh;
  logic [W-1:0]         fr_nxt;

  mexp_key #(.MOD_WIDTH(W)) u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (key_go_r),
    .modulus  (modulus_r),
    .done     (key_done),
    .mod_norm (mn),
    .mu       (mu)
  );

  // shared multiplier: operand product, Barrett quotient estimate, quotient times modulus
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        mul_a = {2'b00, (phase_r == PH_MULT) ? acc_r : pw_r};
        mul_b = {2'b00, pw_r};
      end
      S_RQ: begin
        mul_a = {1'b0, x_r[2*W-1:W-1]};
        mul_b = mu;
      end
      S_RM: begin
        mul_a = {1'b0, q3_r};
        mul_b = {2'b00, mn};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Barrett remainder is below 3m
  always_comb begin
    m1 = {2'b00, mn};
    m2 = {1'b0, mn, 1'b0};
    if (r_r >= m2) begin
      red_full = r_r - m2;
    end else if (r_r >= m1) begin
      red_full = r_r - m1;
    end else begin
      red_full = r_r;
    end
    red    = red_full[W-1:0];
    e_sh   = e_r >> 1;
    fr_nxt = (fr_r >= d_r) ? (fr_r - d_r) : fr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_BASE;
      modulus_r   <= W'(1);
      exponent_r  <= '0;
      dirty_r     <= 1'b1;
      key_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      key_go_r    <= 1'b0;
      out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODULUS: begin
            modulus_r <= cfg_data[W-1:0];
            dirty_r   <= 1'b1;
          end
          REG_EXPONENT: exponent_r <= cfg_data[E-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (exponent_r == '0) begin
              out_r       <= OUT_WIDTH'(1);
              out_valid_r <= 1'b1;
            end else if (modulus_r == '0) begin
              out_r       <= '0;
              out_valid_r <= 1'b1;
            end else begin
              base_r  <= BW'(in_base_value);
              dig_r   <= DGW'(NDIG);
              pw_r    <= '0;
              acc_r   <= W'(1);
              e_r     <= exponent_r;
              phase_r <= PH_BASE;
              if (dirty_r) begin
                dirty_r  <= 1'b0;
                key_go_r <= 1'b1;
                state_r  <= S_KEY;
              end else begin
                state_r <= S_DIG;
              end
            end
          end
        end
        S_KEY: begin
          if (key_done) state_r <= S_DIG;
        end
        S_DIG: begin
          x_r     <= {pw_r, base_r[BW-1 -: W]};
          base_r  <= base_r << W;
          dig_r   <= dig_r - DGW'(1);
          state_r <= S_RQ;
        end
        S_MUL: begin
          x_r     <= mul_p[2*W-1:0];
          state_r <= S_RQ;
        end
        S_RQ: begin
          q3_r    <= mul_p[2*W+1:W+1];
          state_r <= S_RM;
        end
        S_RM: begin
          qm_r    <= mul_p[W+1:0];
          state_r <= S_SUB;
        end
        S_SUB: begin
          r_r     <= x_r[W+1:0] - qm_r;
          state_r <= S_FIX;
        end
        S_FIX: begin
          case (phase_r)
            PH_BASE: begin
              pw_r <= red;
              if (dig_r != '0) begin
                state_r <= S_DIG;
              end else begin
                phase_r <= e_r[0] ? PH_MULT : PH_SQR;
                state_r <= S_MUL;
              end
            end
            PH_MULT: begin
              acc_r <= red;
              if (e_sh != '0) begin
                phase_r <= PH_SQR;
                state_r <= S_MUL;
              end else begin
                fr_r    <= red;
                d_r     <= mn;
                state_r <= S_FIN;
              end
            end
            PH_SQR: begin
              pw_r    <= red;
              e_r     <= e_sh;
              phase_r <= e_sh[0] ? PH_MULT : PH_SQR;
              state_r <= S_MUL;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_FIN: begin
          // fold the result from the normalised modulus down to the true one
          fr_r <= fr_nxt;
          if (d_r == modulus_r) begin
            out_r       <= OUT_WIDTH'(fr_nxt);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            d_r <= d_r >> 1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  // a word being taken wins over a register write in the same cycle
  assign cfg_ready        = (state_r == S_IDLE) && !start;
  assign out_valid        = out_valid_r;
  assign out_power_result = out_r;

endmodule

// ----- hw/rtl/mexp_chk.sv -----
`timescale 1ns / 1ps

module mexp_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_word_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word neither started nor answered");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start && !busy)))
    else $error("result without an accepted word");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mexp_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int WORD_TARGET = 1050;
  localparam int CALM_TAIL   = 120;

  // indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    logic                     typed;
    logic [OUT_WIDTH-1:0]     power;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n         = 1'b0;
  logic                    start         = 1'b0;
  logic                    busy;
  logic [BASE_WIDTH-1:0]   in_base_value = '0;
  logic                    out_valid;
  logic [OUT_WIDTH-1:0]    out_power_result;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;

  logic [MOD_WIDTH_DEF-1:0] key_modulus;
  logic [EXP_WIDTH_DEF-1:0] key_exponent;
  logic [OUT_WIDTH-1:0]     power_due[$];
  logic [OUT_WIDTH-1:0]     power_head;
  stim_row_t                directed_rows[$];
  int                       mismatches  = 0;
  int                       words_sent  = 0;
  int                       cycle_count = 0;

  modular_exponentiation dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_power_result (out_power_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // modulus fits in 32 bits, so each product is exact in 64
  function automatic logic [OUT_WIDTH-1:0] predict_power(logic [BASE_WIDTH-1:0] base);
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] sq;
    int          i;
    m = 64'(key_modulus);
    if (key_exponent == '0) return OUT_WIDTH'(1);
    if (m == 64'd0) return '0;
    sq  = base % m;
    acc = 64'd1 % m;
    for (i = 0; i < EXP_WIDTH_DEF; i++) begin
      if (key_exponent[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[OUT_WIDTH-1:0];
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_MODULUS) key_modulus = data[MOD_WIDTH_DEF-1:0];
    else if (idx == REG_EXPONENT) key_exponent = data[EXP_WIDTH_DEF-1:0];
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    directed_rows.push_back('{ROW_WRITE, idx, data, 1'b0, '0});
  endfunction

  function automatic void add_word(logic [BASE_WIDTH-1:0] base, logic typed,
                                   logic [OUT_WIDTH-1:0] power);
    directed_rows.push_back('{ROW_WORD, REG_MODULUS, base, typed, power});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_modulus();
    logic [31:0] low;
    case ($urandom_range(0, 15))
      0:       low = 32'd1;
      1:       low = 32'd2;
      2:       low = 32'hFFFF_FFFF;
      3:       low = 32'd0;
      4, 5:    low = $urandom_range(3, 1000);
      6:       low = 32'h8000_0000 | $urandom;
      default: begin
        low = $urandom;
        if (low == 32'd0) low = 32'd1;
      end
    endcase
    return {$urandom, low};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_exponent();
    logic [63:0] e;
    int          w;
    case ($urandom_range(0, 9))
      0:       e = 64'd0;
      1:       e = '1;
      2:       e = 64'd1;
      3:       e = 64'd1 << $urandom_range(0, EXP_WIDTH_DEF - 1);
      default: begin
        w = $urandom_range(1, EXP_WIDTH_DEF);
        e = (rand64() & ((64'd1 << w) - 64'd1)) | (64'd1 << (w - 1));
      end
    endcase
    e[63] = $urandom_range(0, 1);
    return e;
  endfunction

  function automatic logic [BASE_WIDTH-1:0] pick_base();
    logic [63:0] m;
    m = 64'(key_modulus);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 300));
      3:       return m - 64'd1;
      4:       return m * 64'($urandom);
      5:       return m * 64'($urandom) + 64'($urandom_range(0, 3));
      default: return rand64();
    endcase
  endfunction

  // hold the sender off until every outstanding word has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (power_due.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(logic [BASE_WIDTH-1:0] base, logic typed,
                           logic [OUT_WIDTH-1:0] power, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_base_value <= base;
    @(posedge clk);
    while (busy) @(posedge clk);
    power_due.push_back(typed ? power : predict_power(base));
    words_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (power_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual power_result %h",
                 $time, out_power_result);
        mismatches++;
      end else begin
        power_head = power_due.pop_front();
        if (out_power_result !== power_head) begin
          $display("%0t: power_result mismatch, expected %h, actual %h",
                   $time, power_head, out_power_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int        phase_len;
    int        gap;
    int        n;
    logic      idle_on;
    stim_row_t row;

    key_modulus  = MOD_WIDTH_DEF'(1);
    key_exponent = '0;

    add_word('0, 1'b1, 32'd1);
    add_word('1, 1'b1, 32'd1);
    add_write(REG_EXPONENT, 64'd1);
    add_word(64'hDEAD_BEEF_0123_4567, 1'b1, 32'd0);
    add_write(REG_MODULUS, 64'h0000_0000_FFFF_FFFF);
    add_word('1, 1'b1, 32'd0);
    add_word(64'h0000_0000_FFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
    add_word(64'd12345, 1'b1, 32'd12345);
    add_write(REG_EXPONENT, 64'd2);
    add_word(64'h0000_0000_FFFF_FFFE, 1'b1, 32'd1);
    add_word(64'h0123_4567_89AB_CDEF, 1'b0, '0);
    add_write(REG_EXPONENT, '1);
    add_word(64'h0000_0000_FFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
    add_word('0, 1'b1, 32'd0);
    add_word(64'd1, 1'b1, 32'd1);
    add_word(64'd2, 1'b0, '0);
    // upper half dropped: modulus zero
    add_write(REG_MODULUS, 64'hFFFF_FFFF_0000_0000);
    add_word(64'd5, 1'b1, 32'd0);
    // top bit dropped: exponent zero
    add_write(REG_EXPONENT, 64'h8000_0000_0000_0000);
    add_word(64'd5, 1'b1, 32'd1);
    add_write(REG_SPARE_LO, 64'd7);
    add_write(REG_SPARE_HI, '1);
    add_word(64'd9, 1'b1, 32'd1);
    add_write(REG_MODULUS, 64'd2);
    add_write(REG_EXPONENT, 64'd3);
    add_word(64'd3, 1'b1, 32'd1);
    add_word(64'd4, 1'b1, 32'd0);
    add_word('1, 1'b1, 32'd1);
    add_write(REG_MODULUS, 64'h0000_0000_8000_0000);
    add_write(REG_EXPONENT, 64'd1);
    add_word('1, 1'b1, 32'h7FFF_FFFF);
    add_write(REG_MODULUS, 64'd1_000_000_007);
    add_write(REG_EXPONENT, 64'h4000_0000_0000_0000);
    add_word(64'd3, 1'b0, '0);
    add_word('1, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.data);
      else send_word(row.data, row.typed, row.power, 0);
    end

    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 5))
        0:       write_reg(REG_MODULUS, pick_modulus());
        1:       write_reg(REG_EXPONENT, pick_exponent());
        default: begin
          write_reg(REG_MODULUS, pick_modulus());
          write_reg(REG_EXPONENT, pick_exponent());
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(0, 3)), rand64());
      idle_on   = ($urandom_range(0, 2) != 0);
      phase_len = $urandom_range(4, 30);
      for (n = 0; n < phase_len && words_sent < WORD_TARGET; n++) begin
        gap = 0;
        if (idle_on && words_sent < WORD_TARGET - CALM_TAIL && $urandom_range(0, 2) == 0)
          gap = $urandom_range(1, 5);
        if (words_sent < WORD_TARGET - CALM_TAIL && $urandom_range(0, 49) == 0) drain();
        send_word(pick_base(), 1'b0, '0, gap);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (power_due.size() != 0) begin
      $display("%0t: %0d words outstanding, expected %h first, actual none",
               $time, power_due.size(), power_due[0]);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
